### rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check sampled on the rising clock edge, muted while reset is active.
`define SWMS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Same check, but also evaluated while reset is active.
`define SWMS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/swms_pkg.sv
package swms_pkg;

  localparam int unsigned DATA_W  = 16;
  localparam int unsigned TOTAL_W = 48;
  localparam int unsigned CFG_W   = 7;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_WORK
  } swms_state_e;

  // Values broadcast to every cell of the sorting row.
  typedef struct packed {
    logic              en;
    logic              full;
    logic [DATA_W-1:0] sample;
    logic [DATA_W-1:0] evict;
  } swms_bcast_t;

  // What a cell tells its neighbours about its move in this update.
  typedef struct packed {
    logic live;
    logic mv_r;
    logic mv_l;
  } swms_move_t;

endpackage

### rtl/swms_ram.sv
module swms_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [ADDR_W-1:0]    waddr_i,
  input  logic [WIDTH-1:0]     wdata_i,
  input  logic                 re_i,
  input  logic [ADDR_W-1:0]    raddr_i,
  output logic [WIDTH-1:0]     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/swms_cell.sv
`include "assert_macros.svh"

module swms_cell #(
  parameter int unsigned AGE_W = 7
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  swms_pkg::swms_bcast_t          bc_i,
  input  logic [AGE_W-1:0]               km1_i,
  input  logic                           live_i,
  input  swms_pkg::swms_move_t           left_mv_i,
  input  logic [swms_pkg::DATA_W-1:0]    left_val_i,
  input  logic [AGE_W-1:0]               left_age_i,
  input  swms_pkg::swms_move_t           right_mv_i,
  input  logic [swms_pkg::DATA_W-1:0]    right_val_i,
  input  logic [AGE_W-1:0]               right_age_i,
  output swms_pkg::swms_move_t           mv_o,
  output logic [swms_pkg::DATA_W-1:0]    val_o,
  output logic [AGE_W-1:0]               age_o,
  output logic [swms_pkg::DATA_W-1:0]    nval_o
);

  logic [swms_pkg::DATA_W-1:0] val_q, val_d;
  logic [AGE_W-1:0]            age_q, age_d;
  logic                        evicted, alive, plus, minus, stay;

  // The oldest entry of a full window leaves; the others move one place
  // towards the gap it leaves and one place away from the insert point.
  assign evicted = live_i && bc_i.full && (age_q == km1_i);
  assign alive   = live_i && !evicted;
  assign plus    = alive && (val_q > bc_i.sample);
  assign minus   = alive && bc_i.full && (val_q >= bc_i.evict);
  assign stay    = alive && (plus == minus);

  always_comb begin
    mv_o.live = live_i;
    mv_o.mv_r = plus && !minus;
    mv_o.mv_l = minus && !plus;
  end

  always_comb begin
    if (left_mv_i.mv_r) begin
      val_d = left_val_i;
      age_d = AGE_W'(left_age_i + 1'b1);
    end else if (stay) begin
      val_d = val_q;
      age_d = AGE_W'(age_q + 1'b1);
    end else if (right_mv_i.mv_l) begin
      val_d = right_val_i;
      age_d = AGE_W'(right_age_i + 1'b1);
    end else begin
      val_d = bc_i.sample;
      age_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (bc_i.en) begin
      val_q <= val_d;
      age_q <= age_d;
    end
  end

  assign val_o  = val_q;
  assign age_o  = age_q;
  assign nval_o = val_d;

  `SWMS_ASSERT(a_one_source, clk_i, rst_ni,
               bc_i.en |-> $onehot0({left_mv_i.mv_r, stay, right_mv_i.mv_l}),
               "cell takes data from more than one neighbour")
  `SWMS_ASSERT(a_sorted, clk_i, rst_ni,
               (live_i && right_mv_i.live) |-> (val_q <= right_val_i),
               "occupied cells are out of ascending order")

endmodule

### rtl/sliding_window_median_sum.sv
// Channel   Direction  Width  Contents
// s_axis    in         16     sample
// m_axis    out        64     median (low 16 bits), median_total (upper 48 bits)
// cfg       in         7      window_length, write only
//
// For each sample, the acceptance cycle reads the history memory for the sample that
// leaves the window, and the work state then updates the whole cell row at once.
// The history memory's registered read port makes the update wait for that read; a new
// sample is not accepted until the update of the last one has been done.
// Reset leaves an empty window of length one and a zero running total; no clearing
// pass is needed. The update cycle stalls only while a result is due and the output
// register still holds an earlier result that has not been taken.
`include "assert_macros.svh"

module sliding_window_median_sum #(
  parameter int unsigned WINDOW_MAX = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // cfg_wdata_i: window_length [6:0]
  input  logic                   cfg_we_i,
  input  logic [6:0]             cfg_wdata_i,
  // s_axis_tdata: sample [15:0]
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [15:0]            s_axis_tdata,
  // m_axis_tdata: median [15:0], median_total [63:16]
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [63:0]            m_axis_tdata
);

  localparam int unsigned DW      = swms_pkg::DATA_W;
  localparam int unsigned TW      = swms_pkg::TOTAL_W;
  // Counts, ages and window lengths all fit in the range 0 to WINDOW_MAX.
  localparam int unsigned CW      = $clog2(WINDOW_MAX + 1);
  localparam int unsigned LW      = CW + 1;
  localparam int unsigned IW      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  // The window is placed in the row so that its lower median always lands in
  // this one cell, whatever the window length.
  localparam int unsigned MED_IDX = (WINDOW_MAX - 1) / 2;

  swms_pkg::swms_state_e st_q, st_d;

  logic [CW-1:0] k_q, k_d;
  logic [CW-1:0] km1_q;
  logic [CW-1:0] base_q, base_d;
  logic [CW-1:0] fill_q, fill_next;
  logic [IW-1:0] wp_q;
  logic [DW-1:0] sample_q;
  logic [TW-1:0] total_q, total_next;
  logic          out_valid_q;
  logic [63:0]   out_data_q;

  logic          accept, go, full, res;
  logic [IW-1:0] raddr;
  logic [LW-1:0] wp_ext, k_ext;
  logic [DW-1:0] evict_val, median;

  swms_pkg::swms_bcast_t bc;
  swms_pkg::swms_move_t  mv   [WINDOW_MAX];
  logic [DW-1:0]         val  [WINDOW_MAX];
  logic [CW-1:0]         age  [WINDOW_MAX];
  logic [DW-1:0]         nval [WINDOW_MAX];
  logic                  live [WINDOW_MAX];

  assign accept = s_axis_tvalid && s_axis_tready;
  assign full   = (fill_q == k_q);
  assign fill_next = full ? fill_q : CW'(fill_q + 1'b1);
  assign res    = (fill_next == k_q);

  // Window length as written, with zero read as one and large values held at
  // the row length; the base cell follows from it.
  always_comb begin
    if (cfg_wdata_i == '0) begin
      k_d = CW'(1);
    end else if (32'(cfg_wdata_i) > WINDOW_MAX) begin
      k_d = CW'(WINDOW_MAX);
    end else begin
      k_d = CW'(cfg_wdata_i);
    end
    base_d = CW'(MED_IDX) - CW'((k_d - 1'b1) >> 1);
  end

  // Next state.
  always_comb begin
    st_d = st_q;
    case (st_q)
      swms_pkg::ST_IDLE: begin
        if (accept) begin
          st_d = swms_pkg::ST_WORK;
        end
      end
      swms_pkg::ST_WORK: begin
        if (go) begin
          st_d = swms_pkg::ST_IDLE;
        end
      end
      default: st_d = swms_pkg::ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    s_axis_tready = 1'b0;
    go            = 1'b0;
    case (st_q)
      swms_pkg::ST_IDLE: s_axis_tready = 1'b1;
      swms_pkg::ST_WORK: go = !res || !out_valid_q || m_axis_tready;
      default: begin
        s_axis_tready = 1'b0;
        go            = 1'b0;
      end
    endcase
  end

  // The sample leaving a full window is the one accepted k transactions ago.
  assign wp_ext = LW'(wp_q);
  assign k_ext  = LW'(k_q);
  always_comb begin
    if (wp_ext >= k_ext) begin
      raddr = IW'(wp_ext - k_ext);
    end else begin
      raddr = IW'(wp_ext + LW'(WINDOW_MAX) - k_ext);
    end
  end

  swms_ram #(
    .WIDTH (DW),
    .DEPTH (WINDOW_MAX)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (go),
    .waddr_i (wp_q),
    .wdata_i (sample_q),
    .re_i    (accept),
    .raddr_i (raddr),
    .rdata_o (evict_val)
  );

  always_comb begin
    bc.en     = go;
    bc.full   = full;
    bc.sample = sample_q;
    bc.evict  = evict_val;
  end

  // The occupied cells are base .. base + fill - 1.
  for (genvar j = 0; j < WINDOW_MAX; j++) begin : g_cell
    localparam logic [LW-1:0] JIDX = LW'(j);
    swms_pkg::swms_move_t lmv, rmv;
    logic [DW-1:0]        lval, rval;
    logic [CW-1:0]        lage, rage;

    assign live[j] = (JIDX >= LW'(base_q)) && (JIDX < (LW'(base_q) + LW'(fill_q)));

    if (j == 0) begin : g_left_end
      assign lmv  = '0;
      assign lval = '0;
      assign lage = '0;
    end else begin : g_left
      assign lmv  = mv[j-1];
      assign lval = val[j-1];
      assign lage = age[j-1];
    end

    if (j == WINDOW_MAX - 1) begin : g_right_end
      assign rmv  = '0;
      assign rval = '0;
      assign rage = '0;
    end else begin : g_right
      assign rmv  = mv[j+1];
      assign rval = val[j+1];
      assign rage = age[j+1];
    end

    swms_cell #(
      .AGE_W (CW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .bc_i        (bc),
      .km1_i       (km1_q),
      .live_i      (live[j]),
      .left_mv_i   (lmv),
      .left_val_i  (lval),
      .left_age_i  (lage),
      .right_mv_i  (rmv),
      .right_val_i (rval),
      .right_age_i (rage),
      .mv_o        (mv[j]),
      .val_o       (val[j]),
      .age_o       (age[j]),
      .nval_o      (nval[j])
    );
  end

  assign median     = nval[MED_IDX];
  assign total_next = total_q + TW'(median);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= swms_pkg::ST_IDLE;
      k_q         <= CW'(1);
      km1_q       <= '0;
      base_q      <= CW'(MED_IDX);
      fill_q      <= '0;
      wp_q        <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (cfg_we_i) begin
        // A new window length starts an empty window; the total carries on.
        k_q    <= k_d;
        km1_q  <= CW'(k_d - 1'b1);
        base_q <= base_d;
        fill_q <= '0;
      end else if (go) begin
        fill_q <= fill_next;
      end
      if (go) begin
        wp_q <= (wp_q == IW'(WINDOW_MAX - 1)) ? '0 : IW'(wp_q + 1'b1);
        if (res) begin
          total_q <= total_next;
        end
      end
      if (go && res) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sample_q <= s_axis_tdata;
    end
    if (go && res) begin
      out_data_q <= {total_next, median};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  `SWMS_ASSERT(a_fill_bound, clk_i, rst_ni, fill_q <= k_q,
               "window holds more samples than its length")
  `SWMS_ASSERT(a_median_cell, clk_i, rst_ni,
               (go && res) |-> ((base_q <= CW'(MED_IDX)) &&
                                ((LW'(base_q) + LW'(k_q)) > LW'(MED_IDX))),
               "median cell lies outside the occupied window")
  `SWMS_ASSERT(a_result_full, clk_i, rst_ni,
               ($rose(out_valid_q) && !$past(cfg_we_i)) |-> (fill_q == k_q),
               "result delivered from a window that is not full")

endmodule
